FILE: rtl/pve_pkg.sv
// ----------------------------------------------------------------------------
// pve_pkg: shared types and constants for the pose velocity estimator
// Sequencer states, fixed-point limits, CORDIC arctangent table and the
// term layout of the quaternion delta product.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pve_pkg;

    // divider operand widths
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = 48;

    // reset value of the minimum interval register
    localparam logic [19:0] MIN_INTERVAL_RESET = 20'd1000;

    // fixed-point constants
    localparam logic signed [32:0] MEGA       = 33'sd1000000;
    localparam logic signed [33:0] NORM_LIMIT = 34'sd26843;
    localparam logic [30:0]        SIN_LIMIT  = 31'd1073741;
    localparam logic signed [33:0] HALF_PI    = 34'sd1686629713;
    localparam logic signed [49:0] W_LIM_P    = 50'sd1073741824;
    localparam logic signed [49:0] W_LIM_N    = -50'sd1073741824;
    localparam logic signed [49:0] DQ_LIM_P   = 50'sd70368744177664;
    localparam logic signed [49:0] DQ_LIM_N   = -50'sd70368744177664;
    localparam logic [61:0]        ONE_Q60    = 62'h1000000000000000;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PREP,
        S_LMUL,
        S_LDIV,
        S_LWAIT,
        S_NMUL,
        S_NACC,
        S_PMUL,
        S_PACC,
        S_QDIV,
        S_QWAIT,
        S_WMUL,
        S_SQINIT,
        S_SQRT,
        S_CINIT,
        S_CORDIC,
        S_GMUL,
        S_GDIV,
        S_GWAIT,
        S_UDIV,
        S_UWAIT,
        S_AMUL,
        S_AACC,
        S_ASAT,
        S_DONE
    } t_state;

    // one product term of p = q1 * conj(q0)
    typedef struct packed {
        logic [1:0] q1_sel;
        logic [1:0] q0_sel;
        logic       neg;
    } t_pterm;

    // term index: [3:2] component, [1:0] term within component
    function automatic t_pterm pterm(input logic [3:0] t);
        t_pterm r;
        r.q1_sel = (t[1:0] == 2'd0) ? 2'd3 : (t[1:0] - 2'd1);
        unique case (t)
            4'd0:  begin r.q0_sel = 2'd0; r.neg = 1'b1; end
            4'd1:  begin r.q0_sel = 2'd3; r.neg = 1'b0; end
            4'd2:  begin r.q0_sel = 2'd2; r.neg = 1'b1; end
            4'd3:  begin r.q0_sel = 2'd1; r.neg = 1'b0; end
            4'd4:  begin r.q0_sel = 2'd1; r.neg = 1'b1; end
            4'd5:  begin r.q0_sel = 2'd2; r.neg = 1'b0; end
            4'd6:  begin r.q0_sel = 2'd3; r.neg = 1'b0; end
            4'd7:  begin r.q0_sel = 2'd0; r.neg = 1'b1; end
            4'd8:  begin r.q0_sel = 2'd2; r.neg = 1'b1; end
            4'd9:  begin r.q0_sel = 2'd1; r.neg = 1'b1; end
            4'd10: begin r.q0_sel = 2'd0; r.neg = 1'b0; end
            4'd11: begin r.q0_sel = 2'd3; r.neg = 1'b0; end
            4'd12: begin r.q0_sel = 2'd3; r.neg = 1'b0; end
            4'd13: begin r.q0_sel = 2'd0; r.neg = 1'b0; end
            4'd14: begin r.q0_sel = 2'd1; r.neg = 1'b0; end
            default: begin r.q0_sel = 2'd2; r.neg = 1'b0; end
        endcase
        return r;
    endfunction

    // arctan(2^-i) in Q30, truncated
    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] r;
        unique case (i)
            5'd0:  r = 30'd843314856;
            5'd1:  r = 30'd497837829;
            5'd2:  r = 30'd263043836;
            5'd3:  r = 30'd133525158;
            5'd4:  r = 30'd67021686;
            5'd5:  r = 30'd33543515;
            5'd6:  r = 30'd16775850;
            5'd7:  r = 30'd8388437;
            5'd8:  r = 30'd4194282;
            5'd9:  r = 30'd2097149;
            5'd10: r = 30'd1048575;
            5'd11: r = 30'd524287;
            5'd12: r = 30'd262143;
            5'd13: r = 30'd131071;
            5'd14: r = 30'd65535;
            5'd15: r = 30'd32767;
            5'd16: r = 30'd16383;
            5'd17: r = 30'd8191;
            5'd18: r = 30'd4095;
            5'd19: r = 30'd2047;
            5'd20: r = 30'd1023;
            5'd21: r = 30'd511;
            5'd22: r = 30'd255;
            5'd23: r = 30'd127;
            5'd24: r = 30'd63;
            5'd25: r = 30'd31;
            5'd26: r = 30'd15;
            5'd27: r = 30'd7;
            5'd28: r = 30'd3;
            5'd29: r = 30'd1;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

    // saturate a signed 64-bit value to 32 bits
    function automatic logic [31:0] sat32(input logic signed [63:0] v);
        logic [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'h7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'h80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/pve_div.sv
// ----------------------------------------------------------------------------
// pve_div: iterative signed divider
// Restoring division, one quotient bit per cycle, quotient truncated toward
// zero. The divisor is taken as positive.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pve_div (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire logic signed [pve_pkg::DIV_NUM_W-1:0] i_num,
    input  wire logic        [pve_pkg::DIV_DEN_W-1:0] i_den,
    output logic                                      o_done,
    output logic signed      [pve_pkg::DIV_NUM_W-1:0] o_quot
);

    localparam int NW = pve_pkg::DIV_NUM_W;
    localparam int DW = pve_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_num;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic          r_neg;

    logic [NW-1:0] w_mag;
    logic [DW:0]   w_rem_sh;
    logic          w_ge;
    logic [DW:0]   w_rem_sub;

    // numerator magnitude and one restoring step
    assign w_mag     = i_num[NW-1] ? (~i_num + 1'b1) : i_num;
    assign w_rem_sh  = {r_rem, r_num[NW-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: quotient bits shift into the numerator register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= w_mag;
            r_rem <= '0;
            r_den <= i_den;
            r_neg <= i_num[NW-1];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_rem_sub[DW-1:0] : w_rem_sh[DW-1:0];
            r_num <= {r_num[NW-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? $signed(~r_num + 1'b1) : $signed(r_num);

endmodule

`default_nettype wire

FILE: rtl/pose_velocity_estimator.sv
// ----------------------------------------------------------------------------
// pose_velocity_estimator: linear and angular velocity from head pose samples
// Finite-difference linear velocity and quaternion-delta angular velocity,
// computed by a small sequencer around one multiplier and one divider.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (i_s_*) carries one pose sample per item; master stream
//   (o_m_*) returns one velocity result per sample, in order.
//   i_cfg_we/i_cfg_wdata write the minimum sample interval (microseconds);
//   write it only while the block is idle.
//   The block takes one item at a time: o_s_tready is high only while the
//   sequencer is idle. A first sample, or one with no update, goes straight
//   to the result; a full linear and angular update runs up to eleven
//   divisions on the one-bit-per-cycle divider, plus a 31-step square root
//   and a 30-step CORDIC.
//   Results sit in an output register; the next item is accepted while a
//   result waits, and the sequencer holds its finished result until the
//   output register is free when the receiver stalls.
//   Synchronous active-low reset clears the previous sample, the held
//   angular velocity and the sample counter, and sets the interval to 1000.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pose_velocity_estimator (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // slave: pos_x[31:0] pos_y[63:32] pos_z[95:64] quat_x[111:96]
    //        quat_y[127:112] quat_z[143:128] quat_w[159:144] time_us[207:160]
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [207:0] i_s_tdata,
    // master: lin_vel_x[31:0] lin_vel_y[63:32] lin_vel_z[95:64]
    //         ang_vel_x[127:96] ang_vel_y[159:128] ang_vel_z[191:160]
    //         sample_index[223:192]
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [223:0]      o_m_tdata,
    // configuration: min_interval_us
    input  wire logic         i_cfg_we,
    input  wire logic [19:0]  i_cfg_wdata
);

    pve_pkg::t_state r_state, n_state;

    // configuration and sample history
    logic [19:0]        r_min;
    logic               r_have;
    logic [31:0]        r_idx;
    logic signed [31:0] r_last_pos [3];
    logic signed [15:0] r_q0 [4];
    logic [47:0]        r_last_t;

    // current sample
    logic signed [31:0] r_pos [3];
    logic signed [15:0] r_q1 [4];
    logic [47:0]        r_t;

    // working registers
    logic [47:0]        r_d;
    logic               r_ang_ok;
    logic [1:0]         r_k;
    logic [4:0]         r_cnt;
    logic signed [65:0] r_prod;
    logic signed [33:0] r_sum;
    logic [32:0]        r_norm;
    logic signed [33:0] r_p [4];
    logic signed [49:0] r_dq [4];
    logic [61:0]        r_v;
    logic [61:0]        r_res;
    logic [61:0]        r_bit;
    logic [30:0]        r_s;
    logic signed [33:0] r_x;
    logic signed [33:0] r_y;
    logic signed [33:0] r_z;
    logic signed [55:0] r_g;
    logic signed [43:0] r_u;
    logic [97:0]        r_acc;
    logic [31:0]        r_lin [3];
    logic [31:0]        r_hav [3];

    // output register
    logic               r_ovalid;
    logic [223:0]       r_odata;

    // combinational helpers
    logic               w_in_acc;
    logic [47:0]        w_d;
    logic [47:0]        w_min48;
    logic               w_lin_ok;
    logic               w_ang_ok;
    logic signed [32:0] w_dp;
    logic signed [31:0] w_w;
    logic signed [49:0] w_c;
    logic [42:0]        w_ua;
    logic [54:0]        w_ub;
    logic [43:0]        w_u_neg;
    logic [55:0]        w_g_neg;
    pve_pkg::t_pterm    w_pt;
    logic signed [33:0] w_term;
    logic signed [33:0] w_sum_add;
    logic signed [32:0] w_ma;
    logic signed [32:0] w_mb;
    logic [61:0]        w_trial;
    logic               w_sq_ge;
    logic [61:0]        w_res_next;
    logic signed [33:0] w_xsh;
    logic signed [33:0] w_ysh;
    logic signed [33:0] w_atan;
    logic [1:0]         w_shsel;
    logic [97:0]        w_pp_sh;
    logic [67:0]        w_mq;
    logic               w_aneg;
    logic [31:0]        w_asat;
    logic               w_out_free;

    // divider port
    logic                                      w_div_start;
    logic signed [pve_pkg::DIV_NUM_W-1:0]      w_div_num;
    logic        [pve_pkg::DIV_DEN_W-1:0]      w_div_den;
    logic                                      w_div_done;
    logic signed [pve_pkg::DIV_NUM_W-1:0]      w_div_quot;

    pve_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    assign o_s_tready = (r_state == pve_pkg::S_IDLE);
    assign w_in_acc   = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_ovalid || i_m_tready;

    // interval and update conditions
    assign w_d      = r_t - r_last_t;
    assign w_min48  = {28'd0, r_min};
    assign w_lin_ok = r_have && !w_d[47] && (w_d > w_min48);
    assign w_ang_ok = r_have && !w_d[47] && (w_d >= w_min48) && (w_d != 48'd0);

    // position delta for the current axis
    assign w_dp = {r_pos[r_k][31], r_pos[r_k]} - {r_last_pos[r_k][31], r_last_pos[r_k]};

    // cosine of half angle, clamped
    always_comb begin
        if (r_dq[3] > pve_pkg::W_LIM_P) begin
            w_w = 32'sd1073741824;
        end else if (r_dq[3] < pve_pkg::W_LIM_N) begin
            w_w = -32'sd1073741824;
        end else begin
            w_w = r_dq[3][31:0];
        end
    end

    // axis component, clamped before division
    always_comb begin
        if (r_dq[r_k] > pve_pkg::DQ_LIM_P) begin
            w_c = pve_pkg::DQ_LIM_P;
        end else if (r_dq[r_k] < pve_pkg::DQ_LIM_N) begin
            w_c = pve_pkg::DQ_LIM_N;
        end else begin
            w_c = r_dq[r_k];
        end
    end

    // magnitudes for the final product
    assign w_u_neg = -r_u;
    assign w_g_neg = -r_g;
    assign w_ua    = r_u[43] ? w_u_neg[42:0] : r_u[42:0];
    assign w_ub    = r_g[55] ? w_g_neg[54:0] : r_g[54:0];

    // quaternion product term accumulate
    assign w_pt      = pve_pkg::pterm(r_cnt[3:0]);
    assign w_term    = r_prod[33:0];
    assign w_sum_add = (r_state == pve_pkg::S_PACC && w_pt.neg) ? (r_sum - w_term)
                                                                : (r_sum + w_term);

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            pve_pkg::S_LMUL: begin
                w_ma = w_dp;
                w_mb = pve_pkg::MEGA;
            end
            pve_pkg::S_NMUL: begin
                w_ma = {{17{r_q0[r_cnt[1:0]][15]}}, r_q0[r_cnt[1:0]]};
                w_mb = {{17{r_q0[r_cnt[1:0]][15]}}, r_q0[r_cnt[1:0]]};
            end
            pve_pkg::S_PMUL: begin
                w_ma = {{17{r_q1[w_pt.q1_sel][15]}}, r_q1[w_pt.q1_sel]};
                w_mb = {{17{r_q0[w_pt.q0_sel][15]}}, r_q0[w_pt.q0_sel]};
            end
            pve_pkg::S_WMUL: begin
                w_ma = {w_w[31], w_w};
                w_mb = {w_w[31], w_w};
            end
            pve_pkg::S_GMUL: begin
                w_ma = r_z[32:0];
                w_mb = pve_pkg::MEGA;
            end
            pve_pkg::S_AMUL: begin
                w_ma = {1'b0, r_cnt[0] ? {21'd0, w_ua[42:32]} : w_ua[31:0]};
                w_mb = {1'b0, r_cnt[1] ? {9'd0, w_ub[54:32]} : w_ub[31:0]};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // divider operand select
    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = r_d;
        unique case (r_state)
            pve_pkg::S_LDIV: begin
                w_div_start = 1'b1;
                w_div_num   = r_prod[63:0];
            end
            pve_pkg::S_QDIV: begin
                w_div_start = 1'b1;
                w_div_num   = {r_p[r_k], 30'd0};
                w_div_den   = {15'd0, r_norm};
            end
            pve_pkg::S_GDIV: begin
                w_div_start = 1'b1;
                w_div_num   = {r_prod[62:0], 1'b0};
            end
            pve_pkg::S_UDIV: begin
                w_div_start = 1'b1;
                w_div_num   = {w_c[47:0], 16'd0};
                w_div_den   = {17'd0, r_s};
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    // square root step
    assign w_trial    = r_res + r_bit;
    assign w_sq_ge    = (r_v >= w_trial);
    assign w_res_next = w_sq_ge ? ((r_res >> 1) + r_bit) : (r_res >> 1);

    // CORDIC step
    assign w_xsh  = r_x >>> r_cnt;
    assign w_ysh  = r_y >>> r_cnt;
    assign w_atan = {4'd0, pve_pkg::atan_q30(r_cnt)};

    // partial product placement and final saturation
    assign w_shsel = {1'b0, r_cnt[0]} + {1'b0, r_cnt[1]};
    assign w_pp_sh = {34'd0, r_prod[63:0]} << {w_shsel, 5'd0};
    assign w_mq    = r_acc[97:30];
    assign w_aneg  = r_u[43] ^ r_g[55];

    always_comb begin
        if (w_aneg) begin
            if ((w_mq[67:32] != 36'd0) || (w_mq[31] && (w_mq[30:0] != 31'd0))) begin
                w_asat = 32'h80000000;
            end else begin
                w_asat = -w_mq[31:0];
            end
        end else begin
            if (w_mq[67:31] != 37'd0) begin
                w_asat = 32'h7FFFFFFF;
            end else begin
                w_asat = w_mq[31:0];
            end
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pve_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pve_pkg::S_IDLE: begin
                if (w_in_acc) n_state = pve_pkg::S_PREP;
            end
            pve_pkg::S_PREP: begin
                if (w_lin_ok) n_state = pve_pkg::S_LMUL;
                else if (w_ang_ok) n_state = pve_pkg::S_NMUL;
                else n_state = pve_pkg::S_DONE;
            end
            pve_pkg::S_LMUL:  n_state = pve_pkg::S_LDIV;
            pve_pkg::S_LDIV:  n_state = pve_pkg::S_LWAIT;
            pve_pkg::S_LWAIT: begin
                if (w_div_done) begin
                    if (r_k != 2'd2) n_state = pve_pkg::S_LMUL;
                    else if (r_ang_ok) n_state = pve_pkg::S_NMUL;
                    else n_state = pve_pkg::S_DONE;
                end
            end
            pve_pkg::S_NMUL:  n_state = pve_pkg::S_NACC;
            pve_pkg::S_NACC: begin
                if (r_cnt[1:0] != 2'd3) n_state = pve_pkg::S_NMUL;
                else if (w_sum_add <= pve_pkg::NORM_LIMIT) n_state = pve_pkg::S_DONE;
                else n_state = pve_pkg::S_PMUL;
            end
            pve_pkg::S_PMUL:  n_state = pve_pkg::S_PACC;
            pve_pkg::S_PACC: begin
                if (r_cnt[3:0] == 4'd15) n_state = pve_pkg::S_QDIV;
                else n_state = pve_pkg::S_PMUL;
            end
            pve_pkg::S_QDIV:  n_state = pve_pkg::S_QWAIT;
            pve_pkg::S_QWAIT: begin
                if (w_div_done) begin
                    if (r_k == 2'd3) n_state = pve_pkg::S_WMUL;
                    else n_state = pve_pkg::S_QDIV;
                end
            end
            pve_pkg::S_WMUL:   n_state = pve_pkg::S_SQINIT;
            pve_pkg::S_SQINIT: n_state = pve_pkg::S_SQRT;
            pve_pkg::S_SQRT: begin
                if (r_cnt == 5'd30) n_state = pve_pkg::S_CINIT;
            end
            pve_pkg::S_CINIT: begin
                if (r_s <= pve_pkg::SIN_LIMIT) n_state = pve_pkg::S_DONE;
                else n_state = pve_pkg::S_CORDIC;
            end
            pve_pkg::S_CORDIC: begin
                if (r_cnt == 5'd29) n_state = pve_pkg::S_GMUL;
            end
            pve_pkg::S_GMUL:  n_state = pve_pkg::S_GDIV;
            pve_pkg::S_GDIV:  n_state = pve_pkg::S_GWAIT;
            pve_pkg::S_GWAIT: begin
                if (w_div_done) n_state = pve_pkg::S_UDIV;
            end
            pve_pkg::S_UDIV:  n_state = pve_pkg::S_UWAIT;
            pve_pkg::S_UWAIT: begin
                if (w_div_done) n_state = pve_pkg::S_AMUL;
            end
            pve_pkg::S_AMUL:  n_state = pve_pkg::S_AACC;
            pve_pkg::S_AACC: begin
                if (r_cnt[1:0] == 2'd3) n_state = pve_pkg::S_ASAT;
                else n_state = pve_pkg::S_AMUL;
            end
            pve_pkg::S_ASAT: begin
                if (r_k == 2'd2) n_state = pve_pkg::S_DONE;
                else n_state = pve_pkg::S_UDIV;
            end
            pve_pkg::S_DONE: begin
                if (w_out_free) n_state = pve_pkg::S_IDLE;
            end
            default: n_state = pve_pkg::S_IDLE;
        endcase
    end

    // control state: configuration, sample history, held angular velocity, counter, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= pve_pkg::MIN_INTERVAL_RESET;
            r_have   <= 1'b0;
            r_idx    <= 32'd0;
            r_ovalid <= 1'b0;
            r_last_t <= 48'd0;
            for (int i = 0; i < 3; i++) begin
                r_last_pos[i] <= 32'sd0;
                r_hav[i]      <= 32'd0;
            end
            for (int i = 0; i < 4; i++) begin
                r_q0[i] <= 16'sd0;
            end
        end else begin
            if (i_cfg_we) r_min <= i_cfg_wdata;
            if (r_state == pve_pkg::S_ASAT) r_hav[r_k] <= w_asat;
            if (r_state == pve_pkg::S_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
                r_have   <= 1'b1;
                r_idx    <= r_idx + 32'd1;
                r_last_t <= r_t;
                for (int i = 0; i < 3; i++) r_last_pos[i] <= r_pos[i];
                for (int i = 0; i < 4; i++) r_q0[i] <= r_q1[i];
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (r_state == pve_pkg::S_DONE && w_out_free) begin
            r_odata <= {r_idx, r_hav[2], r_hav[1], r_hav[0],
                        r_lin[2], r_lin[1], r_lin[0]};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    // sequencer counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= 2'd0;
            r_cnt <= 5'd0;
        end else begin
            unique case (r_state)
                pve_pkg::S_PREP: begin
                    r_k   <= 2'd0;
                    r_cnt <= 5'd0;
                end
                pve_pkg::S_LWAIT: begin
                    if (w_div_done) r_k <= (r_k == 2'd2) ? 2'd0 : (r_k + 2'd1);
                end
                pve_pkg::S_NACC: begin
                    r_cnt <= (r_cnt[1:0] == 2'd3) ? 5'd0 : (r_cnt + 5'd1);
                end
                pve_pkg::S_PACC: begin
                    r_cnt <= (r_cnt[3:0] == 4'd15) ? 5'd0 : (r_cnt + 5'd1);
                    r_k   <= 2'd0;
                end
                pve_pkg::S_QWAIT: begin
                    if (w_div_done) r_k <= r_k + 2'd1;
                end
                pve_pkg::S_SQINIT: r_cnt <= 5'd0;
                pve_pkg::S_SQRT:   r_cnt <= (r_cnt == 5'd30) ? 5'd0 : (r_cnt + 5'd1);
                pve_pkg::S_CINIT:  r_cnt <= 5'd0;
                pve_pkg::S_CORDIC: r_cnt <= (r_cnt == 5'd29) ? 5'd0 : (r_cnt + 5'd1);
                pve_pkg::S_GWAIT: begin
                    if (w_div_done) r_k <= 2'd0;
                end
                pve_pkg::S_UWAIT:  r_cnt <= 5'd0;
                pve_pkg::S_AACC:   r_cnt <= r_cnt + 5'd1;
                pve_pkg::S_ASAT:   r_k <= r_k + 2'd1;
                default: begin
                    r_cnt <= r_cnt;
                end
            endcase
        end
    end

    // shared multiplier, registered product
    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            pve_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    r_pos[0] <= i_s_tdata[31:0];
                    r_pos[1] <= i_s_tdata[63:32];
                    r_pos[2] <= i_s_tdata[95:64];
                    r_q1[0]  <= i_s_tdata[111:96];
                    r_q1[1]  <= i_s_tdata[127:112];
                    r_q1[2]  <= i_s_tdata[143:128];
                    r_q1[3]  <= i_s_tdata[159:144];
                    r_t      <= i_s_tdata[207:160];
                end
            end
            pve_pkg::S_PREP: begin
                r_d      <= w_d;
                r_ang_ok <= w_ang_ok;
                r_sum    <= 34'sd0;
                for (int i = 0; i < 3; i++) r_lin[i] <= 32'd0;
            end
            pve_pkg::S_LWAIT: begin
                if (w_div_done) r_lin[r_k] <= pve_pkg::sat32(w_div_quot);
            end
            pve_pkg::S_NACC: begin
                if (r_cnt[1:0] == 2'd3) begin
                    r_norm <= w_sum_add[32:0];
                    r_sum  <= 34'sd0;
                end else begin
                    r_sum <= w_sum_add;
                end
            end
            pve_pkg::S_PACC: begin
                if (r_cnt[1:0] == 2'd3) begin
                    r_p[r_cnt[3:2]] <= w_sum_add;
                    r_sum           <= 34'sd0;
                end else begin
                    r_sum <= w_sum_add;
                end
            end
            pve_pkg::S_QWAIT: begin
                if (w_div_done) r_dq[r_k] <= w_div_quot[49:0];
            end
            pve_pkg::S_SQINIT: begin
                r_v   <= pve_pkg::ONE_Q60 - {1'b0, r_prod[60:0]};
                r_res <= 62'd0;
                r_bit <= 62'd1 << 60;
            end
            pve_pkg::S_SQRT: begin
                if (w_sq_ge) r_v <= r_v - w_trial;
                r_res <= w_res_next;
                r_bit <= r_bit >> 2;
                if (r_cnt == 5'd30) r_s <= w_res_next[30:0];
            end
            pve_pkg::S_CINIT: begin
                if (w_w < 0) begin
                    r_x <= {3'd0, r_s};
                    r_y <= -{{2{w_w[31]}}, w_w};
                    r_z <= pve_pkg::HALF_PI;
                end else begin
                    r_x <= {{2{w_w[31]}}, w_w};
                    r_y <= {3'd0, r_s};
                    r_z <= 34'sd0;
                end
            end
            pve_pkg::S_CORDIC: begin
                if (r_y > 0) begin
                    r_x <= r_x + w_ysh;
                    r_y <= r_y - w_xsh;
                    r_z <= r_z + w_atan;
                end else begin
                    r_x <= r_x - w_ysh;
                    r_y <= r_y + w_xsh;
                    r_z <= r_z - w_atan;
                end
            end
            pve_pkg::S_GWAIT: begin
                if (w_div_done) r_g <= w_div_quot[55:0];
            end
            pve_pkg::S_UWAIT: begin
                if (w_div_done) begin
                    r_u   <= w_div_quot[43:0];
                    r_acc <= 98'd0;
                end
            end
            pve_pkg::S_AACC: begin
                r_acc <= r_acc + w_pp_sh;
            end
            default: begin
                r_sum <= r_sum;
            end
        endcase
    end

endmodule

`default_nettype wire
